// File: sv/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Shared constants, operation codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int TOTAL_SLOTS_DEF = 8192;
   localparam int WORD_BITS_DEF   = 64;

   localparam int SLOT_W  = 13;
   localparam int LIMIT_W = 14;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd1024;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic capture;
      logic pick_load;
      logic fail_load;
      logic free_mul;
      logic free_rem;
      logic free_read;
      logic free_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic rsp_free;
   } dp_sts_type;

endpackage

// File: sv/bsa_if.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface bsa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [bsa_pkg::SLOT_W-1:0]  free_slot;

   modport source (output valid, output operation, output free_slot, input ready);
   modport sink   (input valid, input operation, input free_slot, output ready);
endinterface

interface bsa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bsa_pkg::SLOT_W-1:0]  slot;
   logic                        full_res;

   modport source (output valid, output slot, output full_res, input ready);
   modport sink   (input valid, input slot, input full_res, output ready);
endinterface

// File: sv/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences the request accept, bitmap scan, pick and free steps.
// ----------------------------------------------------------------------------
module bsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   output logic                 req_ready,
   input  bsa_pkg::dp_sts_type  sts,
   output bsa_pkg::ctl_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_PICK   = 3'd2;
   localparam logic [2:0] ST_FAIL   = 3'd3;
   localparam logic [2:0] ST_FMUL   = 3'd4;
   localparam logic [2:0] ST_FREM   = 3'd5;
   localparam logic [2:0] ST_FREAD  = 3'd6;
   localparam logic [2:0] ST_FWRITE = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = (req_operation == bsa_pkg::OP_ALLOC) ? ST_SCAN : ST_FMUL;
            end
         end
         ST_SCAN: begin
            priority if (sts.hit) begin
               cmd.capture = 1'b1;
               state_in    = ST_PICK;
            end else if (sts.exhausted) begin
               state_in = ST_FAIL;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_PICK: begin
            if (sts.rsp_free) begin
               cmd.pick_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FAIL: begin
            if (sts.rsp_free) begin
               cmd.fail_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_FMUL: begin
            cmd.free_mul = 1'b1;
            state_in     = ST_FREM;
         end
         ST_FREM: begin
            cmd.free_rem = 1'b1;
            state_in     = ST_FREAD;
         end
         ST_FREAD: begin
            cmd.free_read = 1'b1;
            state_in      = ST_FWRITE;
         end
         ST_FWRITE: begin
            if (sts.rsp_free) begin
               cmd.free_load = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_idle_only: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> (state_ff == ST_IDLE) && req_valid)
      else $error("beat accepted outside idle");

   a_scan_after_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && (req_operation == bsa_pkg::OP_ALLOC) |=> state_ff == ST_SCAN)
      else $error("allocate beat did not start a scan");

   a_hit_exclusive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !(sts.hit && sts.exhausted))
      else $error("scan reports hit and exhausted together");

endmodule

// File: sv/bsa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Occupancy RAM with per-word valid bits, scan pointer, lowest-clear-bit
// pick, slot-to-word split for frees, limit register and response register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
   parameter int TOTAL_SLOTS = bsa_pkg::TOTAL_SLOTS_DEF,
   parameter int WORD_BITS   = bsa_pkg::WORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bsa_pkg::LIMIT_W-1:0]  csr_wr_data,
   input  logic [bsa_pkg::SLOT_W-1:0]   req_free_slot,
   input  bsa_pkg::ctl_cmd_type         cmd,
   output bsa_pkg::dp_sts_type          sts,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [bsa_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_full_res
);

   localparam int SLOT_W     = bsa_pkg::SLOT_W;
   localparam int LIMIT_W    = bsa_pkg::LIMIT_W;
   localparam int WORD_COUNT = (TOTAL_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int REM_W      = BIT_W + 1;
   localparam int CAND_W     = $clog2(WORD_COUNT * WORD_BITS) + 1;
   localparam int CMP_W      = (CAND_W > LIMIT_W) ? CAND_W : LIMIT_W;
   localparam int SHIFT      = SLOT_W + 1;
   localparam int RECIP      = (1 << SHIFT) / WORD_BITS;
   localparam int RECIP_W    = SHIFT - 2;
   localparam int PROD_W     = SLOT_W + RECIP_W;

   localparam logic [WIDX_W-1:0]    LAST_WORD = WIDX_W'(WORD_COUNT - 1);
   localparam logic [WORD_BITS-1:0] ONES      = '1;
   localparam logic [CMP_W-1:0]     TOTAL_C   = CMP_W'(TOTAL_SLOTS);

   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;

   logic [LIMIT_W-1:0]    limit_ff;
   logic [SLOT_W-1:0]     fs_ff;
   logic                  in_range_ff;

   logic [WIDX_W-1:0]     scan_ptr_ff;
   logic                  scan_end_ff;
   logic                  rd_pend_ff;
   logic                  rd_last_ff;
   logic [WIDX_W-1:0]     rd_idx_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;

   logic [WORD_BITS-1:0]  hit_word_ff;
   logic [WORD_BITS-1:0]  iso_ff;
   logic [CAND_W-1:0]     base_ff;
   logic [WIDX_W-1:0]     hit_idx_ff;

   logic [PROD_W-1:0]     prod_ff;
   logic [SLOT_W-1:0]     q_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [WIDX_W-1:0]     fq_ff;
   logic [BIT_W-1:0]      fb_ff;

   logic                  rsp_valid_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic                  rsp_full_ff;

   logic [WORD_BITS-1:0]  word;
   logic [WORD_BITS-1:0]  inv;
   logic [WORD_BITS-1:0]  iso_in;
   logic [CAND_W-1:0]     base_in;
   logic [BIT_W-1:0]      bit_pos;
   logic [CAND_W-1:0]     cand;
   logic                  pick_ok;
   logic [PROD_W-1:0]     prod_in;
   logic [SLOT_W-1:0]     q0;
   logic [REM_W-1:0]      rem_in;
   logic                  over;
   logic [SLOT_W-1:0]     qc_in;
   logic [BIT_W-1:0]      bc_in;
   logic                  scan_rd;
   logic                  rd_en;
   logic [WIDX_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [WIDX_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  in_range_in;

   assign word = rd_vld_ff ? rd_data_ff : '0;
   assign inv  = ~word;
   assign iso_in  = inv & (~inv + WORD_BITS'(1));
   assign base_in = CAND_W'(rd_idx_ff) * CAND_W'(WORD_BITS);

   always_comb begin
      bit_pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         bit_pos = bit_pos | (iso_ff[i] ? BIT_W'(i) : '0);
      end
   end

   assign cand    = base_ff + CAND_W'(bit_pos);
   assign pick_ok = (CMP_W'(cand) < CMP_W'(limit_ff)) && (CMP_W'(cand) < TOTAL_C);

   assign in_range_in = CMP_W'(req_free_slot) < TOTAL_C;
   assign prod_in     = PROD_W'(fs_ff) * PROD_W'(RECIP);
   assign q0          = SLOT_W'(prod_ff >> SHIFT);
   assign rem_in      = REM_W'(fs_ff - SLOT_W'(q0 * SLOT_W'(WORD_BITS)));
   assign over        = rem_ff >= REM_W'(WORD_BITS);
   assign qc_in       = over ? q_ff + SLOT_W'(1) : q_ff;
   assign bc_in       = over ? BIT_W'(rem_ff - REM_W'(WORD_BITS)) : BIT_W'(rem_ff);

   assign scan_rd = cmd.scan_step && !scan_end_ff;
   assign rd_en   = scan_rd || (cmd.free_read && in_range_ff);
   assign rd_addr = cmd.free_read ? WIDX_W'(qc_in) : scan_ptr_ff;

   assign wr_en   = (cmd.pick_load && pick_ok) || (cmd.free_load && in_range_ff);
   assign wr_addr = cmd.free_load ? fq_ff : hit_idx_ff;
   assign wr_data = cmd.free_load ? (word & ~(WORD_BITS'(1) << fb_ff))
                                  : (hit_word_ff | iso_ff);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= bsa_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         scan_end_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else if (cmd.accept) begin
         scan_ptr_ff <= '0;
         scan_end_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         rd_pend_ff <= scan_rd;
         rd_last_ff <= scan_ptr_ff == LAST_WORD;
         if (scan_rd) begin
            if (scan_ptr_ff == LAST_WORD) begin
               scan_end_ff <= 1'b1;
            end else begin
               scan_ptr_ff <= scan_ptr_ff + WIDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_rd) begin
         rd_idx_ff <= scan_ptr_ff;
      end
      if (cmd.accept) begin
         fs_ff       <= req_free_slot;
         in_range_ff <= in_range_in;
      end
      if (cmd.capture) begin
         hit_word_ff <= word;
         iso_ff      <= iso_in;
         base_ff     <= base_in;
         hit_idx_ff  <= rd_idx_ff;
      end
      if (cmd.free_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.free_rem) begin
         q_ff   <= q0;
         rem_ff <= rem_in;
      end
      if (cmd.free_read) begin
         fq_ff <= WIDX_W'(qc_in);
         fb_ff <= bc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.pick_load || cmd.fail_load || cmd.free_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick_load) begin
         rsp_slot_ff <= pick_ok ? SLOT_W'(cand) : '0;
         rsp_full_ff <= !pick_ok;
      end else if (cmd.fail_load) begin
         rsp_slot_ff <= '0;
         rsp_full_ff <= 1'b1;
      end else if (cmd.free_load) begin
         rsp_slot_ff <= fs_ff;
         rsp_full_ff <= 1'b0;
      end
   end

   assign sts.hit       = rd_pend_ff && (word != ONES);
   assign sts.exhausted = rd_pend_ff && rd_last_ff && (word == ONES);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_full_res = rsp_full_ff;

   a_grant_onehot: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_load && pick_ok |-> $onehot(iso_ff))
      else $error("granted bit is not a single clear bit");

   a_grant_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.pick_load && pick_ok |=>
         rsp_valid_ff && !rsp_full_ff && (CMP_W'(rsp_slot_ff) < CMP_W'(limit_ff)))
      else $error("granted slot at or above limit");

   a_free_marks_word: assert property (@(posedge clock) disable iff (reset)
      cmd.free_load && in_range_ff |=> valid_ff[$past(fq_ff)])
      else $error("freed word not marked written");

endmodule

// File: sv/bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator
// Hands out the lowest free slot number below a programmable limit and
// takes slots back, keeping one occupancy bit per slot in a bitmap RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. A free goes through a multiply,
// remainder, word read and word write step before its response. An
// allocate reads the bitmap RAM one word per cycle until it finds a word
// with a clear bit, and answers full when every word is full. The RAM
// starts clear after reset through per-word written flags, so no clearing
// pass is needed. The response register lets a new request be accepted
// while the last response is still waiting.
module bitmap_slot_allocator #(
   parameter int TOTAL_SLOTS = bsa_pkg::TOTAL_SLOTS_DEF,
   parameter int WORD_BITS   = bsa_pkg::WORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bsa_pkg::LIMIT_W-1:0]  csr_wr_data,
   bsa_req_if.sink                      req_if,
   bsa_rsp_if.source                    rsp_if
);

   bsa_pkg::ctl_cmd_type cmd;
   bsa_pkg::dp_sts_type  sts;

   bsa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_operation (req_if.operation),
      .req_ready     (req_if.ready),
      .sts           (sts),
      .cmd           (cmd)
   );

   bsa_datapath #(
      .TOTAL_SLOTS (TOTAL_SLOTS),
      .WORD_BITS   (WORD_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_free_slot (req_if.free_slot),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_slot      (rsp_if.slot),
      .rsp_full_res  (rsp_if.full_res)
   );

endmodule
